### rtl/fla_pkg.sv
package fla_pkg;

	localparam int POOL_DEPTH_DEF = 256;
	localparam int OPCODE_W       = 3;
	localparam int SLOT_W         = 8;
	localparam int COUNT_W        = 9;
	localparam int STATUS_W       = 2;

	localparam logic [COUNT_W-1:0] POOL_COUNT_RST = COUNT_W'(256);

	typedef enum logic [OPCODE_W-1:0] {
		OP_INIT    = 3'd0,
		OP_ALLOC   = 3'd1,
		OP_RELEASE = 3'd2,
		OP_SORTED  = 3'd3,
		OP_QUERY   = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FREE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ALLOC,
		ST_WALK,
		ST_FIX
	} state_t;

endpackage

### rtl/fla_link_ram.sv
module fla_link_ram #(
	parameter int DEPTH = fla_pkg::POOL_DEPTH_DEF,
	parameter int WIDTH = $clog2(fla_pkg::POOL_DEPTH_DEF + 1)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/free_list_slot_allocator_top.sv
// Free-list slot allocator: one transaction is taken when start is high and busy is low, and
// exactly one result follows, shown for one cycle with done high; the receiver cannot stall it,
// and busy is already low in that cycle so the next transaction may be taken there. Release,
// any range or empty-pool error and unknown opcodes finish on acceptance, with the result
// registered for the next cycle; alloc passes through ST_ALLOC, init through ST_INIT for
// pool_count (clipped to 1..POOL_DEPTH) entries, query or sorted release through ST_WALK over
// at most POOL_DEPTH links, plus ST_FIX when a sorted release inserts behind an existing entry.
// The walk rate is one link per cycle, set by the link memory's single read port and by each
// read address depending on the previous read. The link memory needs no clearing after reset;
// pool_count resets to 256 and should be written only while busy is low; nothing enforces it.
module free_list_slot_allocator_top #(
	parameter int POOL_DEPTH = fla_pkg::POOL_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fla_pkg::OPCODE_W-1:0]  opcode,
	input  logic [fla_pkg::SLOT_W-1:0]    slot_index,
	input  logic                          pool_count_we,
	input  logic [fla_pkg::COUNT_W-1:0]   pool_count_wdata,
	output logic                          done,
	output logic [fla_pkg::SLOT_W-1:0]    granted_slot,
	output logic [fla_pkg::STATUS_W-1:0]  status,
	output logic                          is_free
);

	import fla_pkg::*;

	localparam int AW    = $clog2(POOL_DEPTH);
	localparam int PTR_W = $clog2(POOL_DEPTH + 1);
	localparam int CW    = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);
	localparam logic [CW-1:0]    DEPTH_C  = CW'(POOL_DEPTH);

	state_t            state_q, nxt_state;
	opcode_t           op_q, op_d;
	logic [PTR_W-1:0]  slot_q, slot_d;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [PTR_W-1:0]  cur_q, cur_d;
	logic [PTR_W-1:0]  prev_q, prev_d;
	logic              prev_vld_q, prev_vld_d;
	logic              use_rd_q, use_rd_d;
	logic [PTR_W-1:0]  step_q, step_d;
	logic [COUNT_W-1:0] pool_count_q;

	logic              done_q;
	logic [SLOT_W-1:0] granted_q;
	status_t           status_q;
	logic              is_free_q;

	logic              fin;
	logic [SLOT_W-1:0] fin_grant;
	status_t           fin_status;
	logic              fin_free;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [PTR_W-1:0]  mem_wd, mem_rd;

	logic [CW-1:0]     pc_ext, n_eff, slot_ext, head_ext;
	logic [PTR_W-1:0]  n_ptr, slot_in, rd_clamped, cur_w, step_inc;
	logic              in_range, walk_end;

	fla_link_ram #(
		.DEPTH (POOL_DEPTH),
		.WIDTH (PTR_W)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (mem_ra),
		.rdata (mem_rd)
	);

	// effective count: zero acts as one, clip to the pool depth
	always_comb begin
		pc_ext = CW'(pool_count_q);
		if (pc_ext == '0) begin
			n_eff = CW'(1);
		end else if (pc_ext > DEPTH_C) begin
			n_eff = DEPTH_C;
		end else begin
			n_eff = pc_ext;
		end
	end

	assign n_ptr      = n_eff[PTR_W-1:0];
	assign slot_ext   = CW'(slot_index);
	assign slot_in    = slot_ext[PTR_W-1:0];
	assign in_range   = slot_ext < n_eff;
	assign head_ext   = CW'(head_q);
	// stray links past the null value end the list
	assign rd_clamped = (mem_rd > NULL_PTR) ? NULL_PTR : mem_rd;
	assign cur_w      = use_rd_q ? rd_clamped : cur_q;
	assign walk_end   = (step_q == NULL_PTR) || (cur_w >= NULL_PTR);
	assign step_inc   = step_q + PTR_W'(1);

	always_comb begin
		nxt_state  = state_q;
		op_d       = op_q;
		slot_d     = slot_q;
		head_d     = head_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		prev_vld_d = prev_vld_q;
		use_rd_d   = use_rd_q;
		step_d     = step_q;
		mem_we     = 1'b0;
		mem_wa     = '0;
		mem_wd     = '0;
		mem_re     = 1'b0;
		mem_ra     = '0;
		fin        = 1'b0;
		fin_grant  = '0;
		fin_status = STAT_OK;
		fin_free   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d   = opcode_t'(opcode);
					slot_d = slot_in;
					case (opcode_t'(opcode)) inside
						OP_INIT: begin
							step_d    = '0;
							nxt_state = ST_INIT;
						end
						OP_ALLOC: begin
							if (head_q >= NULL_PTR) begin
								fin        = 1'b1;
								fin_status = STAT_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_ra    = head_q[AW-1:0];
								nxt_state = ST_ALLOC;
							end
						end
						OP_RELEASE, OP_SORTED, OP_QUERY: begin
							if (!in_range) begin
								fin        = 1'b1;
								fin_status = STAT_RANGE;
							end else if (opcode_t'(opcode) == OP_RELEASE) begin
								mem_we = 1'b1;
								mem_wa = slot_in[AW-1:0];
								mem_wd = head_q;
								head_d = slot_in;
								fin    = 1'b1;
							end else begin
								cur_d      = head_q;
								prev_vld_d = 1'b0;
								use_rd_d   = 1'b0;
								step_d     = '0;
								nxt_state  = ST_WALK;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = step_q[AW-1:0];
				if (step_inc == n_ptr) begin
					mem_wd    = NULL_PTR;
					head_d    = '0;
					fin       = 1'b1;
					nxt_state = ST_IDLE;
				end else begin
					mem_wd = step_inc;
					step_d = step_inc;
				end
			end
			ST_ALLOC: begin
				head_d    = rd_clamped;
				fin       = 1'b1;
				fin_grant = head_ext[SLOT_W-1:0];
				nxt_state = ST_IDLE;
			end
			ST_WALK: begin
				if (!walk_end && cur_w == slot_q) begin
					fin       = 1'b1;
					nxt_state = ST_IDLE;
					if (op_q == OP_QUERY) begin
						fin_free = 1'b1;
					end else begin
						fin_status = STAT_FREE;
					end
				end else if (walk_end || (op_q == OP_SORTED && cur_w > slot_q)) begin
					if (op_q == OP_QUERY) begin
						fin       = 1'b1;
						nxt_state = ST_IDLE;
					end else if (prev_vld_q) begin
						// link the new slot forward, patch the predecessor next cycle
						mem_we    = 1'b1;
						mem_wa    = slot_q[AW-1:0];
						mem_wd    = cur_w;
						nxt_state = ST_FIX;
					end else begin
						mem_we    = 1'b1;
						mem_wa    = slot_q[AW-1:0];
						mem_wd    = head_q;
						head_d    = slot_q;
						fin       = 1'b1;
						nxt_state = ST_IDLE;
					end
				end else begin
					// advance: follow the link of the current entry
					prev_d     = cur_w;
					prev_vld_d = 1'b1;
					mem_re     = 1'b1;
					mem_ra     = cur_w[AW-1:0];
					use_rd_d   = 1'b1;
					step_d     = step_inc;
				end
			end
			ST_FIX: begin
				mem_we    = 1'b1;
				mem_wa    = prev_q[AW-1:0];
				mem_wd    = slot_q;
				fin       = 1'b1;
				nxt_state = ST_IDLE;
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= NULL_PTR;
			pool_count_q <= POOL_COUNT_RST;
			done_q       <= 1'b0;
			prev_vld_q   <= 1'b0;
			use_rd_q     <= 1'b0;
			step_q       <= '0;
		end else begin
			state_q    <= nxt_state;
			head_q     <= head_d;
			done_q     <= fin;
			prev_vld_q <= prev_vld_d;
			use_rd_q   <= use_rd_d;
			step_q     <= step_d;
			if (pool_count_we) begin
				pool_count_q <= pool_count_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		slot_q <= slot_d;
		cur_q  <= cur_d;
		prev_q <= prev_d;
		if (fin) begin
			granted_q <= fin_grant;
			status_q  <= fin_status;
			is_free_q <= fin_free;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign granted_slot = granted_q;
	assign status       = status_q;
	assign is_free      = is_free_q;

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while an operation is still running");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without an accepted transaction");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_wa == mem_ra)))
		else $error("link memory read and written at one entry in one cycle");

	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_free) |-> (status == STAT_OK && granted_slot == '0))
		else $error("free answer together with an error or a grant");
`endif

endmodule
